// ===== hw/rtl/lvsi_pkg.sv =====
package lvsi_pkg;

    // Default geometry of the stamp store.
    localparam int WAYS_DEF       = 8;
    localparam int SETS_DEF       = 256;
    localparam int STAMP_BITS_DEF = 32;

    // Widths of the stream fields.
    localparam int OP_W        = 2;
    localparam int SET_IDX_W   = 8;
    localparam int WAY_IDX_W   = 3;
    localparam int TIME_W      = 32;
    localparam int UMASK_W     = 8;
    localparam int S_TDATA_W   = 56;
    localparam int M_TDATA_W   = 8;

    typedef enum logic [OP_W-1:0] {
        OP_TOUCH  = 2'd0,
        OP_INVAL  = 2'd1,
        OP_VICTIM = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_RESULT
    } t_state;

endpackage

// ===== hw/rtl/lvsi_stamp_mem.sv =====
module lvsi_stamp_mem #(
    parameter int WAYS       = lvsi_pkg::WAYS_DEF,
    parameter int SETS       = lvsi_pkg::SETS_DEF,
    parameter int STAMP_BITS = lvsi_pkg::STAMP_BITS_DEF,
    parameter int SET_W      = (SETS > 1) ? $clog2(SETS) : 1
) (
    input  logic                                i_clk,
    input  logic                                i_wr_en,
    input  logic [SET_W-1:0]                    i_wr_addr,
    input  logic [WAYS-1:0]                     i_wr_way_en,
    input  logic [STAMP_BITS-1:0]               i_wr_data,
    input  logic                                i_rd_en,
    input  logic [SET_W-1:0]                    i_rd_addr,
    output logic [WAYS-1:0][STAMP_BITS-1:0]     o_rd_row
);

    // One row per set, one stamp per way, with a write enable per way.
    logic [WAYS-1:0][STAMP_BITS-1:0] mem [SETS];
    logic [WAYS-1:0][STAMP_BITS-1:0] r_rd_row;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            for (int w = 0; w < WAYS; w++) begin
                if (i_wr_way_en[w]) begin
                    mem[i_wr_addr][w] <= i_wr_data;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_row <= mem[i_rd_addr];
        end
    end

    assign o_rd_row = r_rd_row;

endmodule

// ===== hw/rtl/lru_victim_select_inclusion_aware_top.sv =====
// Touch and invalidate are written at their accepting edge and can be taken back to back.
// A victim query loads the set's row at its accepting edge, then compares one way per cycle
// and stops at the first invalid way; its result goes to the output register, or to a
// holding register while the output stalls, and no item is taken until it is passed on.
// After reset a clearing pass zeroes every way of every set and takes no item; l2_mode
// resets to 0, and configuration writes are accepted whenever no victim query is in flight.
module lru_victim_select_inclusion_aware_top #(
    parameter int WAYS       = lvsi_pkg::WAYS_DEF,
    parameter int SETS       = lvsi_pkg::SETS_DEF,
    parameter int STAMP_BITS = lvsi_pkg::STAMP_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic                             i_cfg_data,     // l2_mode
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // set_index[7:0], way_index[10:8], time_stamp[42:11], upper_mask[50:43]
    input  logic [lvsi_pkg::S_TDATA_W-1:0]   i_s_tdata,
    input  logic [lvsi_pkg::OP_W-1:0]        i_s_tuser,      // operation
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // victim_way[2:0], victim_invalid[3]
    output logic [lvsi_pkg::M_TDATA_W-1:0]   o_m_tdata
);

    localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int KEY_W = STAMP_BITS + 1;

    // Input fields.
    logic [lvsi_pkg::SET_IDX_W-1:0] in_set;
    logic [lvsi_pkg::WAY_IDX_W-1:0] in_way;
    logic [lvsi_pkg::TIME_W-1:0]    in_time;
    logic [lvsi_pkg::UMASK_W-1:0]   in_mask;
    logic [SET_W-1:0]               in_row;
    logic [STAMP_BITS-1:0]          in_stamp;

    assign in_set   = i_s_tdata[7:0];
    assign in_way   = i_s_tdata[10:8];
    assign in_time  = i_s_tdata[42:11];
    assign in_mask  = i_s_tdata[50:43];
    assign in_stamp = STAMP_BITS'(in_time);

    generate
        if (SETS >= 256) begin : g_set_direct
            assign in_row = SET_W'(in_set);
        end else begin : g_set_mod
            // The set index is reduced modulo SETS through a constant table.
            logic [SET_W-1:0] set_mod_tab [256];
            for (genvar k = 0; k < 256; k++) begin : g_tab
                assign set_mod_tab[k] = SET_W'(k % SETS);
            end
            assign in_row = set_mod_tab[in_set];
        end
    endgenerate

    // Registers.
    lvsi_pkg::t_state              r_state, n_state;
    logic [SET_W-1:0]              r_clr_addr, n_clr_addr;
    logic                          r_l2_mode;
    logic [lvsi_pkg::UMASK_W-1:0]  r_mask, n_mask;
    logic [WAY_W-1:0]              r_scan_way, n_scan_way;
    logic [KEY_W-1:0]              r_best_key, n_best_key;
    logic [WAY_W-1:0]              r_best_way, n_best_way;
    logic [lvsi_pkg::WAY_IDX_W-1:0] r_res_way, n_res_way;
    logic                          r_res_inv, n_res_inv;
    logic                          r_out_valid, n_out_valid;
    logic [lvsi_pkg::WAY_IDX_W-1:0] r_out_way, n_out_way;
    logic                          r_out_inv, n_out_inv;

    // Memory ports.
    logic                          wr_en;
    logic [SET_W-1:0]              wr_addr;
    logic [WAYS-1:0]               wr_way_en;
    logic [STAMP_BITS-1:0]         wr_data;
    logic                          rd_en;
    logic [WAYS-1:0][STAMP_BITS-1:0] rd_row;

    lvsi_stamp_mem #(
        .WAYS       (WAYS),
        .SETS       (SETS),
        .STAMP_BITS (STAMP_BITS),
        .SET_W      (SET_W)
    ) u_mem (
        .i_clk       (i_clk),
        .i_wr_en     (wr_en),
        .i_wr_addr   (wr_addr),
        .i_wr_way_en (wr_way_en),
        .i_wr_data   (wr_data),
        .i_rd_en     (rd_en),
        .i_rd_addr   (in_row),
        .o_rd_row    (rd_row)
    );

    // Ways beyond the width of upper_mask are never held above.
    logic [WAYS-1:0] held_vec;
    generate
        for (genvar w = 0; w < WAYS; w++) begin : g_held
            if (w < lvsi_pkg::UMASK_W) begin : g_in
                assign held_vec[w] = r_mask[w];
            end else begin : g_out
                assign held_vec[w] = 1'b0;
            end
        end
    endgenerate

    logic                  s_xfer;
    logic                  slot_free;
    logic [STAMP_BITS-1:0] cur_stamp;
    logic [KEY_W-1:0]      cur_key;
    logic                  take_cur;
    logic                  fin;
    logic [lvsi_pkg::WAY_IDX_W-1:0] fin_way;
    logic                  fin_inv;

    assign o_s_tready = (r_state == lvsi_pkg::ST_IDLE);
    assign s_xfer     = i_s_tvalid && o_s_tready;
    assign slot_free  = !r_out_valid || i_m_tready;

    // The scan orders ways by {held, stamp}, so any free way beats every held way.
    assign cur_stamp = rd_row[r_scan_way];
    assign cur_key   = {r_l2_mode && held_vec[r_scan_way], cur_stamp};
    assign take_cur  = (r_scan_way == '0) || (cur_key < r_best_key);

    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_mask      = r_mask;
        n_scan_way  = r_scan_way;
        n_best_key  = r_best_key;
        n_best_way  = r_best_way;
        n_res_way   = r_res_way;
        n_res_inv   = r_res_inv;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_way   = r_out_way;
        n_out_inv   = r_out_inv;
        wr_en       = 1'b0;
        wr_addr     = in_row;
        wr_way_en   = '0;
        wr_data     = '0;
        rd_en       = 1'b0;
        fin         = 1'b0;
        fin_way     = '0;
        fin_inv     = 1'b0;

        unique case (r_state)
            lvsi_pkg::ST_CLEAR: begin
                wr_en      = 1'b1;
                wr_addr    = r_clr_addr;
                wr_way_en  = '1;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == SET_W'(SETS - 1)) begin
                    n_state = lvsi_pkg::ST_IDLE;
                end
            end
            lvsi_pkg::ST_IDLE: begin
                if (s_xfer) begin
                    case (i_s_tuser)
                        lvsi_pkg::OP_TOUCH, lvsi_pkg::OP_INVAL: begin
                            if (32'(in_way) < WAYS) begin
                                wr_en     = 1'b1;
                                wr_way_en = WAYS'(1) << in_way;
                                wr_data   = (i_s_tuser == lvsi_pkg::OP_TOUCH) ? in_stamp : '0;
                            end
                        end
                        lvsi_pkg::OP_VICTIM: begin
                            rd_en      = 1'b1;
                            n_mask     = in_mask;
                            n_scan_way = '0;
                            n_state    = lvsi_pkg::ST_SCAN;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            lvsi_pkg::ST_SCAN: begin
                if (cur_stamp == '0) begin
                    fin     = 1'b1;
                    fin_way = lvsi_pkg::WAY_IDX_W'(r_scan_way);
                    fin_inv = 1'b1;
                end else begin
                    if (take_cur) begin
                        n_best_key = cur_key;
                        n_best_way = r_scan_way;
                    end
                    if (r_scan_way == WAY_W'(WAYS - 1)) begin
                        fin     = 1'b1;
                        fin_way = take_cur ? lvsi_pkg::WAY_IDX_W'(r_scan_way)
                                           : lvsi_pkg::WAY_IDX_W'(r_best_way);
                    end else begin
                        n_scan_way = r_scan_way + 1'b1;
                    end
                end
                if (fin) begin
                    if (slot_free) begin
                        n_out_valid = 1'b1;
                        n_out_way   = fin_way;
                        n_out_inv   = fin_inv;
                        n_state     = lvsi_pkg::ST_IDLE;
                    end else begin
                        n_res_way = fin_way;
                        n_res_inv = fin_inv;
                        n_state   = lvsi_pkg::ST_RESULT;
                    end
                end
            end
            lvsi_pkg::ST_RESULT: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_way   = r_res_way;
                    n_out_inv   = r_res_inv;
                    n_state     = lvsi_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = lvsi_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lvsi_pkg::ST_CLEAR;
            r_clr_addr  <= '0;
            r_l2_mode   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_l2_mode <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mask     <= n_mask;
        r_scan_way <= n_scan_way;
        r_best_key <= n_best_key;
        r_best_way <= n_best_way;
        r_res_way  <= n_res_way;
        r_res_inv  <= n_res_inv;
        r_out_way  <= n_out_way;
        r_out_inv  <= n_out_inv;
    end

    // The mode must not change under a scan that is still comparing ways.
    assign o_cfg_ready = (r_state != lvsi_pkg::ST_SCAN) && (r_state != lvsi_pkg::ST_RESULT);
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = {4'b0000, r_out_inv, r_out_way};

endmodule

// ===== verif/lru_victim_select_inclusion_aware_top_tb.sv =====
module lru_victim_select_inclusion_aware_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [lvsi_pkg::OP_W-1:0]      t_opcode;
    typedef logic [lvsi_pkg::SET_IDX_W-1:0] t_set;
    typedef logic [lvsi_pkg::WAY_IDX_W-1:0] t_way;
    typedef logic [lvsi_pkg::TIME_W-1:0]    t_stamp;
    typedef logic [lvsi_pkg::UMASK_W-1:0]   t_umask;

    // The fourth operation code has no meaning; the block must drop such items.
    localparam t_opcode OP_SPARE = 2'd3;
    localparam int FIELD_BITS = lvsi_pkg::SET_IDX_W + lvsi_pkg::WAY_IDX_W
                              + lvsi_pkg::TIME_W + lvsi_pkg::UMASK_W;

    typedef struct {
        t_opcode op;
        t_set    set_idx;
        t_way    way;
        t_stamp  stamp;
        t_umask  umask;
    } t_cache_op;

    typedef struct {
        t_way way;
        logic inval;
    } t_victim;

    logic                                 i_clk;
    logic                                 i_rst_n;
    logic                                 i_cfg_valid;
    logic                                 o_cfg_ready;
    logic                                 i_cfg_data;
    logic                                 i_s_tvalid;
    logic                                 o_s_tready;
    logic [lvsi_pkg::S_TDATA_W-1:0]       i_s_tdata;
    t_opcode                              i_s_tuser;
    logic                                 o_m_tvalid;
    logic                                 i_m_tready;
    logic [lvsi_pkg::M_TDATA_W-1:0]       o_m_tdata;

    lru_victim_select_inclusion_aware_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    t_cache_op op_queue[$];
    t_victim   victim_expq[$];

    // Shadow copy of the stamp store and the mode register.
    t_stamp stamp_mem [0:lvsi_pkg::SETS_DEF-1][0:lvsi_pkg::WAYS_DEF-1];
    logic   l2_shadow;

    logic in_xfer;
    logic bursts_on;
    int   s_gap, r_gap;
    int   n_fails, n_items, n_results, n_inval_victims, n_mode_writes;
    t_stamp tick;
    t_set   hot_sets [0:3];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #3_000_000;
        $display("FAIL lru_victim_select_inclusion_aware_top");
        $finish;
    end

    function automatic t_victim predict_victim(input t_set s, input t_umask m);
        t_victim r;
        logic    free_found, held_found, held;
        t_stamp  free_best, held_best, st;
        t_way    free_way, held_way;
        r.way = '0;
        r.inval = 1'b0;
        free_found = 1'b0;
        held_found = 1'b0;
        free_best = '0;
        held_best = '0;
        free_way = '0;
        held_way = '0;
        for (int w = 0; w < lvsi_pkg::WAYS_DEF; w++) begin
            st = stamp_mem[s][w];
            if (!r.inval) begin
                if (st == '0) begin
                    r.way = w[lvsi_pkg::WAY_IDX_W-1:0];
                    r.inval = 1'b1;
                end else begin
                    held = l2_shadow && m[w];
                    if (held) begin
                        if (!held_found || st < held_best) begin
                            held_found = 1'b1;
                            held_best = st;
                            held_way = w[lvsi_pkg::WAY_IDX_W-1:0];
                        end
                    end else if (!free_found || st < free_best) begin
                        free_found = 1'b1;
                        free_best = st;
                        free_way = w[lvsi_pkg::WAY_IDX_W-1:0];
                    end
                end
            end
        end
        if (!r.inval)
            r.way = free_found ? free_way : held_way;
        return r;
    endfunction

    // Checker and predictor: both sample at the rising edge.
    always @(posedge i_clk) begin
        t_victim got, want;
        t_set    s;
        t_way    w;
        in_xfer = i_s_tvalid && (o_s_tready === 1'b1);
        if (!i_rst_n) begin
            for (int i = 0; i < lvsi_pkg::SETS_DEF; i++)
                for (int j = 0; j < lvsi_pkg::WAYS_DEF; j++)
                    stamp_mem[i][j] = '0;
            l2_shadow = 1'b0;
            in_xfer = 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready === 1'b1) begin
                l2_shadow = i_cfg_data;
                n_mode_writes++;
            end
            if (o_m_tvalid === 1'b1 && i_m_tready) begin
                got.way = o_m_tdata[2:0];
                got.inval = o_m_tdata[3];
                if (victim_expq.size() == 0) begin
                    $error("unexpected victim result, tdata=%h", o_m_tdata);
                    n_fails++;
                end else begin
                    want = victim_expq.pop_front();
                    n_results++;
                    if (want.inval)
                        n_inval_victims++;
                    if (got.way !== want.way) begin
                        $error("victim_way expected %0d actual %0d", want.way, got.way);
                        n_fails++;
                    end
                    if (got.inval !== want.inval) begin
                        $error("victim_invalid expected %0d actual %0d",
                               want.inval, got.inval);
                        n_fails++;
                    end
                end
            end
            if (in_xfer) begin
                n_items++;
                s = i_s_tdata[7:0];
                w = i_s_tdata[10:8];
                case (i_s_tuser)
                    lvsi_pkg::OP_TOUCH:  stamp_mem[s][w] = i_s_tdata[42:11];
                    lvsi_pkg::OP_INVAL:  stamp_mem[s][w] = '0;
                    lvsi_pkg::OP_VICTIM:
                        victim_expq.push_back(predict_victim(s, i_s_tdata[50:43]));
                    default: ;
                endcase
            end
        end
    end

    // Sender: a new item goes out once the previous transfer has completed.
    always @(negedge i_clk) begin
        t_cache_op it;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else if (!i_s_tvalid || in_xfer) begin
            if (s_gap > 0) begin
                s_gap--;
                i_s_tvalid <= 1'b0;
            end else if (op_queue.size() == 0) begin
                i_s_tvalid <= 1'b0;
            end else if (bursts_on && $urandom_range(0, 9) == 0) begin
                s_gap = $urandom_range(0, 16);
                i_s_tvalid <= 1'b0;
            end else begin
                it = op_queue.pop_front();
                i_s_tuser <= it.op;
                i_s_tdata <= {{(lvsi_pkg::S_TDATA_W - FIELD_BITS){1'b0}},
                              it.umask, it.stamp, it.way, it.set_idx};
                i_s_tvalid <= 1'b1;
            end
        end
    end

    // Receiver with random stall bursts.
    always @(negedge i_clk) begin
        if (r_gap > 0) begin
            r_gap--;
            i_m_tready <= 1'b0;
        end else if (bursts_on && $urandom_range(0, 9) == 0) begin
            r_gap = $urandom_range(0, 16);
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    task automatic push_op(input t_opcode op, input t_set s, input t_way w,
                           input t_stamp st, input t_umask m);
        t_cache_op it;
        it.op = op;
        it.set_idx = s;
        it.way = w;
        it.stamp = st;
        it.umask = m;
        op_queue.push_back(it);
    endtask

    // Touches and invalidates give no result, so allow the pipeline to empty as well.
    task automatic wait_quiet();
        while (op_queue.size() != 0 || i_s_tvalid || victim_expq.size() != 0)
            @(posedge i_clk);
        repeat (lvsi_pkg::WAYS_DEF + 6) @(posedge i_clk);
    endtask

    task automatic write_mode(input logic v);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic queue_random_ops(input int count);
        int      r, rs;
        t_opcode op;
        t_set    s;
        t_stamp  st;
        t_umask  m;
        for (int i = 0; i < 4; i++)
            hot_sets[i] = t_set'($urandom_range(0, lvsi_pkg::SETS_DEF - 1));
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            if (r < 55)
                op = lvsi_pkg::OP_TOUCH;
            else if (r < 63)
                op = lvsi_pkg::OP_INVAL;
            else if (r < 93)
                op = lvsi_pkg::OP_VICTIM;
            else
                op = OP_SPARE;
            // Most traffic stays on a few sets so that they fill up completely.
            s = ($urandom_range(0, 99) < 85)
                ? hot_sets[$urandom_range(0, 3)]
                : t_set'($urandom_range(0, lvsi_pkg::SETS_DEF - 1));
            tick = tick + $urandom_range(0, 3);
            rs = $urandom_range(0, 99);
            if (rs < 70)
                st = tick;
            else if (rs < 85)
                st = $urandom;
            else if (rs < 90)
                st = '1;
            else if (rs < 95)
                st = '0;
            else
                st = $urandom_range(1, 4);
            rs = $urandom_range(0, 9);
            m = (rs == 0) ? 8'h00 : (rs == 1) ? 8'hFF : t_umask'($urandom_range(0, 255));
            push_op(op, s, t_way'($urandom_range(0, lvsi_pkg::WAYS_DEF - 1)), st, m);
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        i_s_tuser = lvsi_pkg::OP_TOUCH;
        i_m_tready = 1'b0;
        in_xfer = 1'b0;
        bursts_on = 1'b1;
        s_gap = 0;
        r_gap = 0;
        n_fails = 0;
        n_items = 0;
        n_results = 0;
        n_inval_victims = 0;
        n_mode_writes = 0;
        tick = 32'd16;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        write_mode(1'b0);
        // Plain LRU: empty set, ties, all-ones stamp, zero-stamp touch, unused code.
        push_op(lvsi_pkg::OP_VICTIM, 8'd0, 3'd5, 32'd0, 8'h00);
        push_op(lvsi_pkg::OP_TOUCH, 8'd0, 3'd0, 32'd5, 8'h00);
        push_op(lvsi_pkg::OP_TOUCH, 8'd0, 3'd1, 32'd3, 8'h00);
        push_op(lvsi_pkg::OP_TOUCH, 8'd0, 3'd2, 32'd3, 8'h00);
        push_op(lvsi_pkg::OP_TOUCH, 8'd0, 3'd3, 32'd9, 8'h00);
        push_op(lvsi_pkg::OP_TOUCH, 8'd0, 3'd4, 32'hFFFF_FFFF, 8'h00);
        push_op(lvsi_pkg::OP_TOUCH, 8'd0, 3'd5, 32'd7, 8'h00);
        push_op(lvsi_pkg::OP_TOUCH, 8'd0, 3'd6, 32'd3, 8'h00);
        push_op(lvsi_pkg::OP_TOUCH, 8'd0, 3'd7, 32'd8, 8'h00);
        push_op(lvsi_pkg::OP_VICTIM, 8'd0, 3'd7, 32'd0, 8'hFF);
        push_op(lvsi_pkg::OP_TOUCH, 8'd0, 3'd7, 32'd0, 8'h00);
        push_op(lvsi_pkg::OP_VICTIM, 8'd0, 3'd0, 32'd0, 8'h00);
        push_op(lvsi_pkg::OP_TOUCH, 8'd0, 3'd7, 32'd1, 8'h00);
        push_op(OP_SPARE, 8'd0, 3'd0, 32'd0, 8'hFF);
        push_op(lvsi_pkg::OP_VICTIM, 8'd0, 3'd0, 32'hFFFF_FFFF, 8'h00);
        push_op(lvsi_pkg::OP_INVAL, 8'd255, 3'd7, 32'hFFFF_FFFF, 8'hFF);
        push_op(lvsi_pkg::OP_TOUCH, 8'd255, 3'd7, 32'hFFFF_FFFF, 8'hFF);
        push_op(lvsi_pkg::OP_VICTIM, 8'd255, 3'd7, 32'd0, 8'hFF);
        wait_quiet();

        write_mode(1'b1);
        // Inclusion-aware choice with the held mask at its extremes.
        push_op(lvsi_pkg::OP_TOUCH, 8'd0, 3'd3, 32'd2, 8'h00);
        push_op(lvsi_pkg::OP_VICTIM, 8'd0, 3'd0, 32'd0, 8'h02);
        push_op(lvsi_pkg::OP_VICTIM, 8'd0, 3'd0, 32'd0, 8'h80);
        push_op(lvsi_pkg::OP_VICTIM, 8'd0, 3'd0, 32'd0, 8'hFF);
        push_op(lvsi_pkg::OP_VICTIM, 8'd0, 3'd0, 32'd0, 8'h00);
        push_op(lvsi_pkg::OP_VICTIM, 8'd0, 3'd0, 32'd0, 8'h88);
        push_op(lvsi_pkg::OP_INVAL, 8'd0, 3'd2, 32'd0, 8'h00);
        push_op(lvsi_pkg::OP_VICTIM, 8'd0, 3'd0, 32'd0, 8'hFF);
        wait_quiet();

        for (int ph = 0; ph < 5; ph++) begin
            write_mode(ph[0]);
            if (ph == 4)
                bursts_on = 1'b0;
            queue_random_ops(215);
            wait_quiet();
        end

        $display("Ran %0d items in both victim modes over %0d mode writes.",
                 n_items, n_mode_writes);
        $display("Checked %0d victim results, %0d of them on an invalid way.",
                 n_results, n_inval_victims);
        if (n_fails == 0)
            $display("PASS lru_victim_select_inclusion_aware_top");
        else
            $display("FAIL lru_victim_select_inclusion_aware_top");
        $finish;
    end

endmodule
